// ----- src/cpu_alu_with_flags_defines.svh -----
`ifndef CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_DEFINES_SVH

// same-cycle implication on the rising edge of clk
`define CALU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alu check failed");

// next-cycle implication on the rising edge of clk
`define CALU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alu check failed");

`endif

// ----- src/calu_pkg.sv -----
package calu_pkg;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_INC   = 5'd8,
		OP_DEC   = 5'd9,
		OP_RLC   = 5'd10,
		OP_RRC   = 5'd11,
		OP_RL    = 5'd12,
		OP_RR    = 5'd13,
		OP_SLA   = 5'd14,
		OP_SRA   = 5'd15,
		OP_SRL   = 5'd16,
		OP_SWAP  = 5'd17,
		OP_BIT   = 5'd18,
		OP_RES   = 5'd19,
		OP_SET   = 5'd20,
		OP_DAA   = 5'd21,
		OP_CPL   = 5'd22,
		OP_SCF   = 5'd23,
		OP_CCF   = 5'd24,
		OP_RLCA  = 5'd25,
		OP_RRCA  = 5'd26,
		OP_RLA   = 5'd27,
		OP_RRA   = 5'd28,
		OP_ADD16 = 5'd29,
		OP_INC16 = 5'd30,
		OP_DEC16 = 5'd31
	} op_t;

	localparam logic [7:0]  DAA_HI_LIMIT = 8'h99;
	localparam logic [3:0]  DAA_LO_LIMIT = 4'h9;
	localparam logic [7:0]  DAA_LO_CORR  = 8'h06;
	localparam logic [7:0]  DAA_HI_CORR  = 8'h60;
	localparam logic [3:0]  NIBBLE_MAX   = 4'hF;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] a;
		logic [15:0] b;
		logic [2:0]  bit_index;
		flags_t      fl;
	} calu_in_t;

	typedef struct packed {
		op_t         op;
		flags_t      fl;
		logic [15:0] r;
		logic        h;
		logic        c;
		logic        z_alt;
	} calu_exec_t;

	typedef struct packed {
		logic [15:0] r;
		flags_t      fl;
	} calu_out_t;

endpackage

// ----- src/cpu_alu_with_flags.sv -----
// channel  | direction | handshake            | payload
// in       | input     | in_valid / in_ready  | operation, operand_a, operand_b, bit_index,
//          |           |                      | zero_in, subtract_in, half_in, carry_in
// out      | output    | out_valid / out_ready| result, zero_out, subtract_out, half_out,
//          |           |                      | carry_out
//
// three register stages: input capture, execute (adders, shifter, daa), flag and zero merge
// one beat per cycle sustained while out_ready stays high; out_valid rises once the beat
// has passed the input, execute and merge registers
// arst_n clears the stage valid bits only; no other state
// a stall on out_ready holds the output stage and backs up stage by stage; a bubble is filled
module cpu_alu_with_flags (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  operation,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	input  logic [2:0]  bit_index,
	input  logic        zero_in,
	input  logic        subtract_in,
	input  logic        half_in,
	input  logic        carry_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result,
	output logic        zero_out,
	output logic        subtract_out,
	output logic        half_out,
	output logic        carry_out
);

	logic valid_s1, valid_s2, valid_s3;
	logic rdy_s2, rdy_s3;

	calu_pkg::calu_in_t   data_s1;
	calu_pkg::calu_exec_t data_s2;
	calu_pkg::calu_out_t  data_s3;
	calu_pkg::calu_exec_t ex_d;
	calu_pkg::calu_out_t  res_d;

	assign rdy_s3   = !valid_s3 || out_ready;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign in_ready = !valid_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1.op        <= calu_pkg::op_t'(operation);
			data_s1.a         <= operand_a;
			data_s1.b         <= operand_b;
			data_s1.bit_index <= bit_index;
			data_s1.fl        <= '{z: zero_in, n: subtract_in, h: half_in, c: carry_in};
		end
		if (valid_s1 && rdy_s2) data_s2 <= ex_d;
		if (valid_s2 && rdy_s3) data_s3 <= res_d;
	end

	calu_exec u_exec (
		.s1 (data_s1),
		.ex (ex_d)
	);

	calu_flags u_flags (
		.ex  (data_s2),
		.res (res_d)
	);

	assign out_valid    = valid_s3;
	assign result       = data_s3.r;
	assign zero_out     = data_s3.fl.z;
	assign subtract_out = data_s3.fl.n;
	assign half_out     = data_s3.fl.h;
	assign carry_out    = data_s3.fl.c;

endmodule

// ----- src/calu_exec.sv -----
module calu_exec (
	input  calu_pkg::calu_in_t   s1,
	output calu_pkg::calu_exec_t ex
);

	logic [7:0] a;
	logic [7:0] b;
	logic       k;
	logic [8:0] sum8;
	logic [4:0] sum4;
	logic [8:0] dif8;
	logic [4:0] dif4;
	logic [7:0] mask;
	logic       daa_lo;
	logic       daa_hi;
	logic [7:0] daa_corr;
	logic [16:0] sum16;
	logic [12:0] sum12;

	assign a = s1.a[7:0];
	assign b = s1.b[7:0];
	assign k = ((s1.op == calu_pkg::OP_ADC) || (s1.op == calu_pkg::OP_SBC)) ? s1.fl.c : 1'b0;
	assign sum8 = {1'b0, a} + {1'b0, b} + {8'd0, k};
	assign sum4 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, k};
	assign dif8 = {1'b0, a} - {1'b0, b} - {8'd0, k};
	assign dif4 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, k};
	assign mask = 8'b1 << s1.bit_index;
	assign sum16 = {1'b0, s1.a} + {1'b0, s1.b};
	assign sum12 = {1'b0, s1.a[11:0]} + {1'b0, s1.b[11:0]};

	always_comb begin
		if (!s1.fl.n) begin
			daa_lo = s1.fl.h || (a[3:0] > calu_pkg::DAA_LO_LIMIT);
			daa_hi = s1.fl.c || (a > calu_pkg::DAA_HI_LIMIT);
		end else begin
			daa_lo = s1.fl.h;
			daa_hi = s1.fl.c;
		end
		daa_corr = (daa_lo ? calu_pkg::DAA_LO_CORR : 8'h00) |
			(daa_hi ? calu_pkg::DAA_HI_CORR : 8'h00);
	end

	always_comb begin
		ex.op    = s1.op;
		ex.fl    = s1.fl;
		ex.r     = 16'h0000;
		ex.h     = 1'b0;
		ex.c     = s1.fl.c;
		ex.z_alt = 1'b0;
		case (s1.op)
			calu_pkg::OP_ADD, calu_pkg::OP_ADC: begin
				ex.r = {8'h00, sum8[7:0]};
				ex.h = sum4[4];
				ex.c = sum8[8];
			end
			calu_pkg::OP_SUB, calu_pkg::OP_SBC: begin
				ex.r = {8'h00, dif8[7:0]};
				ex.h = dif4[4];
				ex.c = dif8[8];
			end
			calu_pkg::OP_CP: begin
				ex.r     = s1.a;
				ex.h     = dif4[4];
				ex.c     = dif8[8];
				ex.z_alt = (dif8[7:0] == 8'h00);
			end
			calu_pkg::OP_AND: begin
				ex.r = {8'h00, a & b};
				ex.h = 1'b1;
				ex.c = 1'b0;
			end
			calu_pkg::OP_XOR: begin
				ex.r = {8'h00, a ^ b};
				ex.c = 1'b0;
			end
			calu_pkg::OP_OR: begin
				ex.r = {8'h00, a | b};
				ex.c = 1'b0;
			end
			calu_pkg::OP_INC: begin
				ex.r = {8'h00, a + 8'd1};
				ex.h = (a[3:0] == calu_pkg::NIBBLE_MAX);
			end
			calu_pkg::OP_DEC: begin
				ex.r = {8'h00, a - 8'd1};
				ex.h = (a[3:0] == 4'h0);
			end
			calu_pkg::OP_RLC, calu_pkg::OP_RLCA: begin
				ex.r = {8'h00, a[6:0], a[7]};
				ex.c = a[7];
			end
			calu_pkg::OP_RRC, calu_pkg::OP_RRCA: begin
				ex.r = {8'h00, a[0], a[7:1]};
				ex.c = a[0];
			end
			calu_pkg::OP_RL, calu_pkg::OP_RLA: begin
				ex.r = {8'h00, a[6:0], s1.fl.c};
				ex.c = a[7];
			end
			calu_pkg::OP_RR, calu_pkg::OP_RRA: begin
				ex.r = {8'h00, s1.fl.c, a[7:1]};
				ex.c = a[0];
			end
			calu_pkg::OP_SLA: begin
				ex.r = {8'h00, a[6:0], 1'b0};
				ex.c = a[7];
			end
			calu_pkg::OP_SRA: begin
				ex.r = {8'h00, a[7], a[7:1]};
				ex.c = a[0];
			end
			calu_pkg::OP_SRL: begin
				ex.r = {8'h00, 1'b0, a[7:1]};
				ex.c = a[0];
			end
			calu_pkg::OP_SWAP: begin
				ex.r = {8'h00, a[3:0], a[7:4]};
				ex.c = 1'b0;
			end
			calu_pkg::OP_BIT: begin
				ex.r     = s1.a;
				ex.h     = 1'b1;
				ex.z_alt = ((a & mask) == 8'h00);
			end
			calu_pkg::OP_RES: begin
				ex.r = {8'h00, a & ~mask};
				ex.h = s1.fl.h;
			end
			calu_pkg::OP_SET: begin
				ex.r = {8'h00, a | mask};
				ex.h = s1.fl.h;
			end
			calu_pkg::OP_DAA: begin
				ex.r = {8'h00, s1.fl.n ? (a - daa_corr) : (a + daa_corr)};
				ex.c = daa_hi;
			end
			calu_pkg::OP_CPL: begin
				ex.r = {8'h00, ~a};
				ex.h = 1'b1;
			end
			calu_pkg::OP_SCF: begin
				ex.r = s1.a;
				ex.c = 1'b1;
			end
			calu_pkg::OP_CCF: begin
				ex.r = s1.a;
				ex.c = ~s1.fl.c;
			end
			calu_pkg::OP_ADD16: begin
				ex.r = sum16[15:0];
				ex.h = sum12[12];
				ex.c = sum16[16];
			end
			calu_pkg::OP_INC16: begin
				ex.r = s1.a + 16'd1;
				ex.h = s1.fl.h;
			end
			calu_pkg::OP_DEC16: begin
				ex.r = s1.a - 16'd1;
				ex.h = s1.fl.h;
			end
			default: begin
				ex.r = s1.a;
				ex.h = s1.fl.h;
			end
		endcase
	end

endmodule

// ----- src/calu_flags.sv -----
module calu_flags (
	input  calu_pkg::calu_exec_t ex,
	output calu_pkg::calu_out_t  res
);

	logic r_zero;

	assign r_zero = (ex.r[7:0] == 8'h00);

	always_comb begin
		res.r    = ex.r;
		res.fl.h = ex.h;
		res.fl.c = ex.c;
		res.fl.n = 1'b0;
		res.fl.z = ex.fl.z;
		case (ex.op)
			calu_pkg::OP_ADD, calu_pkg::OP_ADC, calu_pkg::OP_AND, calu_pkg::OP_XOR,
			calu_pkg::OP_OR, calu_pkg::OP_INC, calu_pkg::OP_RLC, calu_pkg::OP_RRC,
			calu_pkg::OP_RL, calu_pkg::OP_RR, calu_pkg::OP_SLA, calu_pkg::OP_SRA,
			calu_pkg::OP_SRL, calu_pkg::OP_SWAP: begin
				res.fl.z = r_zero;
			end
			calu_pkg::OP_SUB, calu_pkg::OP_SBC, calu_pkg::OP_DEC: begin
				res.fl.n = 1'b1;
				res.fl.z = r_zero;
			end
			calu_pkg::OP_CP: begin
				res.fl.n = 1'b1;
				res.fl.z = ex.z_alt;
			end
			calu_pkg::OP_BIT: begin
				res.fl.z = ex.z_alt;
			end
			calu_pkg::OP_RES, calu_pkg::OP_SET, calu_pkg::OP_INC16,
			calu_pkg::OP_DEC16: begin
				res.fl.n = ex.fl.n;
			end
			calu_pkg::OP_DAA: begin
				res.fl.n = ex.fl.n;
				res.fl.z = r_zero;
			end
			calu_pkg::OP_CPL: begin
				res.fl.n = 1'b1;
			end
			calu_pkg::OP_RLCA, calu_pkg::OP_RRCA, calu_pkg::OP_RLA,
			calu_pkg::OP_RRA: begin
				res.fl.z = 1'b0;
			end
			calu_pkg::OP_SCF, calu_pkg::OP_CCF, calu_pkg::OP_ADD16: begin
				res.fl.n = 1'b0;
			end
			default: begin
				res.fl.n = ex.fl.n;
			end
		endcase
	end

endmodule

// ----- src/calu_checker.sv -----
`include "cpu_alu_with_flags_defines.svh"

module calu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] result,
	input logic        zero_out,
	input logic        subtract_out,
	input logic        half_out,
	input logic        carry_out
);

	logic [2:0]  inflight_q;
	logic [19:0] out_payload;

	assign out_payload = {result, zero_out, subtract_out, half_out, carry_out};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else begin
			inflight_q <= inflight_q + {2'd0, in_valid && in_ready} -
				{2'd0, out_valid && out_ready};
		end
	end

	`CALU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))
	`CALU_ASSERT_NOW(a_stall_full, !in_ready, out_valid)
	`CALU_ASSERT_NOW(a_depth, 1'b1, inflight_q <= 3'd3)
	`CALU_ASSERT_NOW(a_empty_quiet, inflight_q == 3'd0, !out_valid)

endmodule

bind cpu_alu_with_flags calu_checker u_checker (.*);

// ----- bench/tb_cpu_alu_with_flags.sv -----
module tb_cpu_alu_with_flags;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BEATS = 2000;
	localparam int PHASES = 4;

	class alu_result_queue;
		calu_pkg::calu_out_t pending_results[$];
		int errors;
		int beats_in;
		int beats_out;
		bit [31:0] ops_hit;

		function new();
			errors = 0;
			beats_in = 0;
			beats_out = 0;
			ops_hit = '0;
		endfunction

		function calu_pkg::calu_out_t alu_outcome(calu_pkg::calu_in_t x);
			calu_pkg::calu_out_t o;
			logic [7:0] a8, b8, r8, mask, corr;
			logic [15:0] r;
			logic [8:0] t9;
			logic [16:0] t17;
			logic [4:0] nib;
			logic [12:0] low12;
			logic k, z, n, h, c, cy, zset, use_r8;
			a8 = x.a[7:0];
			b8 = x.b[7:0];
			mask = 8'd1 << x.bit_index;
			z = x.fl.z;
			n = x.fl.n;
			h = x.fl.h;
			c = x.fl.c;
			r8 = '0;
			r = '0;
			zset = 1'b1;
			use_r8 = 1'b1;
			case (x.op)
				calu_pkg::OP_ADD, calu_pkg::OP_ADC: begin
					k = (x.op == calu_pkg::OP_ADC) ? c : 1'b0;
					t9 = {1'b0, a8} + {1'b0, b8} + {8'd0, k};
					nib = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, k};
					h = nib[4];
					c = t9[8];
					n = 1'b0;
					r8 = t9[7:0];
				end
				calu_pkg::OP_SUB, calu_pkg::OP_SBC, calu_pkg::OP_CP: begin
					k = (x.op == calu_pkg::OP_SBC) ? c : 1'b0;
					h = {1'b0, a8[3:0]} < ({1'b0, b8[3:0]} + {4'd0, k});
					c = {1'b0, a8} < ({1'b0, b8} + {8'd0, k});
					n = 1'b1;
					r8 = a8 - b8 - {7'd0, k};
					if (x.op == calu_pkg::OP_CP) begin
						z = (r8 == 8'd0);
						zset = 1'b0;
						use_r8 = 1'b0;
						r = x.a;
					end
				end
				calu_pkg::OP_AND: begin
					r8 = a8 & b8; n = 1'b0; h = 1'b1; c = 1'b0;
				end
				calu_pkg::OP_XOR: begin
					r8 = a8 ^ b8; n = 1'b0; h = 1'b0; c = 1'b0;
				end
				calu_pkg::OP_OR: begin
					r8 = a8 | b8; n = 1'b0; h = 1'b0; c = 1'b0;
				end
				calu_pkg::OP_INC: begin
					h = (a8[3:0] == calu_pkg::NIBBLE_MAX); r8 = a8 + 8'd1; n = 1'b0;
				end
				calu_pkg::OP_DEC: begin
					h = (a8[3:0] == 4'd0); r8 = a8 - 8'd1; n = 1'b1;
				end
				calu_pkg::OP_RLC, calu_pkg::OP_RLCA: begin
					c = a8[7]; r8 = {a8[6:0], a8[7]};
				end
				calu_pkg::OP_RRC, calu_pkg::OP_RRCA: begin
					c = a8[0]; r8 = {a8[0], a8[7:1]};
				end
				calu_pkg::OP_RL, calu_pkg::OP_RLA: begin
					r8 = {a8[6:0], c}; c = a8[7];
				end
				calu_pkg::OP_RR, calu_pkg::OP_RRA: begin
					r8 = {c, a8[7:1]}; c = a8[0];
				end
				calu_pkg::OP_SLA: begin
					c = a8[7]; r8 = {a8[6:0], 1'b0};
				end
				calu_pkg::OP_SRA: begin
					c = a8[0]; r8 = {a8[7], a8[7:1]};
				end
				calu_pkg::OP_SRL: begin
					c = a8[0]; r8 = {1'b0, a8[7:1]};
				end
				calu_pkg::OP_SWAP: begin
					c = 1'b0; r8 = {a8[3:0], a8[7:4]};
				end
				calu_pkg::OP_BIT: begin
					z = ((a8 & mask) == 8'd0);
					n = 1'b0; h = 1'b1;
					zset = 1'b0; use_r8 = 1'b0; r = x.a;
				end
				calu_pkg::OP_RES: begin
					r8 = a8 & ~mask; zset = 1'b0;
				end
				calu_pkg::OP_SET: begin
					r8 = a8 | mask; zset = 1'b0;
				end
				calu_pkg::OP_DAA: begin
					corr = 8'd0;
					cy = 1'b0;
					if (!n) begin
						if (h || a8[3:0] > calu_pkg::DAA_LO_LIMIT)
							corr = corr + calu_pkg::DAA_LO_CORR;
						if (c || a8 > calu_pkg::DAA_HI_LIMIT) begin
							corr = corr + calu_pkg::DAA_HI_CORR;
							cy = 1'b1;
						end
						r8 = a8 + corr;
					end else begin
						if (h) corr = corr + calu_pkg::DAA_LO_CORR;
						if (c) begin
							corr = corr + calu_pkg::DAA_HI_CORR;
							cy = 1'b1;
						end
						r8 = a8 - corr;
					end
					h = 1'b0;
					c = cy;
				end
				calu_pkg::OP_CPL: begin
					r8 = ~a8; n = 1'b1; h = 1'b1; zset = 1'b0;
				end
				calu_pkg::OP_SCF: begin
					n = 1'b0; h = 1'b0; c = 1'b1;
					zset = 1'b0; use_r8 = 1'b0; r = x.a;
				end
				calu_pkg::OP_CCF: begin
					n = 1'b0; h = 1'b0; c = ~c;
					zset = 1'b0; use_r8 = 1'b0; r = x.a;
				end
				calu_pkg::OP_ADD16: begin
					t17 = {1'b0, x.a} + {1'b0, x.b};
					low12 = {1'b0, x.a[11:0]} + {1'b0, x.b[11:0]};
					h = low12[12];
					c = t17[16];
					n = 1'b0;
					r = t17[15:0];
					zset = 1'b0; use_r8 = 1'b0;
				end
				calu_pkg::OP_INC16: begin
					r = x.a + 16'd1; zset = 1'b0; use_r8 = 1'b0;
				end
				default: begin
					r = x.a - 16'd1; zset = 1'b0; use_r8 = 1'b0;
				end
			endcase
			if ((x.op >= calu_pkg::OP_RLC && x.op <= calu_pkg::OP_SWAP) ||
				(x.op >= calu_pkg::OP_RLCA && x.op <= calu_pkg::OP_RRA)) begin
				n = 1'b0;
				h = 1'b0;
			end
			if (use_r8) r = {8'h00, r8};
			if (zset) z = (r[7:0] == 8'd0);
			if (x.op >= calu_pkg::OP_RLCA && x.op <= calu_pkg::OP_RRA) z = 1'b0;
			o.r = r;
			o.fl.z = z;
			o.fl.n = n;
			o.fl.h = h;
			o.fl.c = c;
			return o;
		endfunction

		function void note_beat(calu_pkg::calu_in_t x);
			pending_results.push_back(alu_outcome(x));
			ops_hit[x.op] = 1'b1;
			beats_in++;
		endfunction

		function void check_beat(calu_pkg::calu_out_t got);
			calu_pkg::calu_out_t want;
			beats_out++;
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation pending: result %h", got.r);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.r !== want.r) begin
				$error("result mismatch: expected %h actual %h", want.r, got.r);
				errors++;
			end
			if (got.fl.z !== want.fl.z) begin
				$error("zero_out mismatch: expected %b actual %b", want.fl.z, got.fl.z);
				errors++;
			end
			if (got.fl.n !== want.fl.n) begin
				$error("subtract_out mismatch: expected %b actual %b", want.fl.n, got.fl.n);
				errors++;
			end
			if (got.fl.h !== want.fl.h) begin
				$error("half_out mismatch: expected %b actual %b", want.fl.h, got.fl.h);
				errors++;
			end
			if (got.fl.c !== want.fl.c) begin
				$error("carry_out mismatch: expected %b actual %b", want.fl.c, got.fl.c);
				errors++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [4:0] operation;
	logic [15:0] operand_a;
	logic [15:0] operand_b;
	logic [2:0] bit_index;
	logic zero_in;
	logic subtract_in;
	logic half_in;
	logic carry_in;
	logic out_valid;
	logic out_ready;
	logic [15:0] result;
	logic zero_out;
	logic subtract_out;
	logic half_out;
	logic carry_out;

	alu_result_queue board = new();
	int cycle_count = 0;
	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;
	logic [15:0] corner_words[8] = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00,
		16'h0FFF, 16'h000F, 16'h0099, 16'h8000};

	cpu_alu_with_flags uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.bit_index(bit_index),
		.zero_in(zero_in),
		.subtract_in(subtract_in),
		.half_in(half_in),
		.carry_in(carry_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result(result),
		.zero_out(zero_out),
		.subtract_out(subtract_out),
		.half_out(half_out),
		.carry_out(carry_out)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [15:0] pick_word();
		if ($urandom_range(0, 3) == 0) return corner_words[$urandom_range(0, 7)];
		return 16'($urandom);
	endfunction

	function automatic calu_pkg::calu_in_t pick_item();
		calu_pkg::calu_in_t x;
		x.op = calu_pkg::op_t'($urandom_range(0, 31));
		x.a = pick_word();
		x.b = pick_word();
		x.bit_index = 3'($urandom_range(0, 7));
		x.fl = calu_pkg::flags_t'(4'($urandom_range(0, 15)));
		return x;
	endfunction

	function automatic calu_pkg::calu_in_t make_item(calu_pkg::op_t op, logic [15:0] a,
		logic [15:0] b, logic [2:0] bi, logic [3:0] fl);
		calu_pkg::calu_in_t x;
		x.op = op;
		x.a = a;
		x.b = b;
		x.bit_index = bi;
		x.fl = calu_pkg::flags_t'(fl);
		return x;
	endfunction

	task automatic send_beat(input calu_pkg::calu_in_t x);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation = x.op;
		operand_a = x.a;
		operand_b = x.b;
		bit_index = x.bit_index;
		zero_in = x.fl.z;
		subtract_in = x.fl.n;
		half_in = x.fl.h;
		carry_in = x.fl.c;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_beat(x);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = recv_steady ? 0 : $urandom_range(0, 19);
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_beat('{r: result,
				fl: '{z: zero_out, n: subtract_out, h: half_out, c: carry_out}});
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = '0;
		operand_a = '0;
		operand_b = '0;
		bit_index = '0;
		zero_in = 1'b0;
		subtract_in = 1'b0;
		half_in = 1'b0;
		carry_in = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every operation once, operands and flags at their extremes
		for (int i = 0; i < 32; i++) begin
			send_beat(make_item(calu_pkg::op_t'(i), i[0] ? 16'hFFFF : 16'h0000,
				i[1] ? 16'h0000 : 16'hFFFF, 3'(i), i[0] ? 4'hF : 4'h0));
		end
		// carries out of bit 3 and 7, daa after subtract, wide wrap
		send_beat(make_item(calu_pkg::OP_ADD, 16'h000F, 16'h0001, 3'd0, 4'h0));
		send_beat(make_item(calu_pkg::OP_ADC, 16'h00FF, 16'h0000, 3'd0, 4'h1));
		send_beat(make_item(calu_pkg::OP_SBC, 16'h0000, 16'h00FF, 3'd0, 4'h1));
		send_beat(make_item(calu_pkg::OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'h0));
		send_beat(make_item(calu_pkg::OP_DAA, 16'h0000, 16'h0000, 3'd0, 4'h7));
		send_beat(make_item(calu_pkg::OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'h0));
		send_beat(make_item(calu_pkg::OP_ADD16, 16'hFFFF, 16'hFFFF, 3'd0, 4'h0));

		for (int p = 0; p < PHASES; p++) begin
			send_steady = (p == 1) || (p == 3);
			recv_steady = (p == 2) || (p == 3);
			for (int i = 0; i < RANDOM_BEATS / PHASES; i++) begin
				send_beat(pick_item());
			end
			drain_results();
		end
		send_steady = 1'b0;
		recv_steady = 1'b0;

		@(negedge clk);
		in_valid = 1'b0;
		drain_results();
		repeat (10) @(posedge clk);
		$display("%0d beats sent, %0d results checked, %0d of 32 operation codes exercised",
			board.beats_in, board.beats_out, $countones(board.ops_hit));
		$display("random gaps and stalls on both sides plus steady back-to-back phases");
		if (board.errors == 0 && board.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/calu_pkg.sv
src/calu_exec.sv
src/calu_flags.sv
src/cpu_alu_with_flags.sv
src/calu_checker.sv
bench/tb_cpu_alu_with_flags.sv
